FILE: rtl/teha_pkg.sv
// ============================================================================
// teha_pkg
// Shared types and constants for the transfer entropy histogram accumulator.
// ============================================================================
package teha_pkg;

    localparam int BASE_MAX_DEF    = 4;
    localparam int HISTORY_MAX_DEF = 4;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int JOINT_DEPTH = 4096;
    localparam int HIST_DEPTH  = 256;
    localparam int PAIR_DEPTH  = 1024;

    localparam logic [1:0] OP_OBSERVE = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    localparam logic [1:0] SEL_JOINT = 2'd0;
    localparam logic [1:0] SEL_HIST  = 2'd1;
    localparam logic [1:0] SEL_SRC   = 2'd2;
    localparam logic [1:0] SEL_PRED  = 2'd3;

    localparam logic [1:0] CFG_BASE   = 2'd0;
    localparam logic [1:0] CFG_HISTORY = 2'd1;
    localparam logic [1:0] CFG_SERIES = 2'd2;

    // classified command handed from front to back
    typedef struct packed {
        logic [1:0]  op;
        logic        counted;
        logic        bad;
        logic [11:0] joint_idx;
        logic [7:0]  hist_idx;
        logic [9:0]  src_idx;
        logic [9:0]  pred_idx;
        logic        joint_ok;
        logic        src_ok;
        logic        pred_ok;
        logic [1:0]  sel;
        logic [11:0] read_idx;
    } cmd_t;

endpackage

FILE: rtl/transfer_entropy_histogram_accumulator.sv
// ============================================================================
// transfer_entropy_histogram_accumulator
// Builds four transfer entropy histograms from paired symbol series.
// ============================================================================
// path: front command register, then back command register with the histogram
// read, then result registers; the back takes a new command only when idle
// clear: a sweep over all 4096 histogram addresses before its result
// reset: synchronous active low; a clearing sweep follows reset,
// during which one item can be taken and held until the sweep ends
module transfer_entropy_histogram_accumulator #(
    parameter int COUNT_WIDTH = teha_pkg::COUNT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [1:0]  s_source_symbol,
    input  logic [1:0]  s_dest_symbol,
    input  logic [1:0]  s_table_select,
    input  logic [11:0] s_read_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_counted,
    output logic        m_bad_symbol,
    output logic [11:0] m_joint_index,
    output logic [7:0]  m_history_index,
    output logic [9:0]  m_source_index,
    output logic [9:0]  m_predicate_index,
    output logic [31:0] m_read_count,
    output logic [31:0] m_total_observations
);
    import teha_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_ready;

    teha_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(s_valid), .in_ready(s_ready),
        .operation(s_operation), .source_symbol(s_source_symbol),
        .dest_symbol(s_dest_symbol), .table_select(s_table_select),
        .read_index(s_read_index),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd));

    teha_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_counted(m_counted), .m_bad_symbol(m_bad_symbol),
        .m_joint_index(m_joint_index), .m_history_index(m_history_index),
        .m_source_index(m_source_index), .m_predicate_index(m_predicate_index),
        .m_read_count(m_read_count), .m_total_observations(m_total_observations));
endmodule

FILE: rtl/teha_ram.sv
// ============================================================================
// teha_ram
// Generic RAM with separate write and read addresses and registered read.
// ============================================================================
module teha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/teha_front.sv
// ============================================================================
// teha_front
// Series tracking and index formation; one command per accepted item.
// ============================================================================
module teha_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          operation,
    input  logic [1:0]          source_symbol,
    input  logic [1:0]          dest_symbol,
    input  logic [1:0]          table_select,
    input  logic [11:0]         read_index,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output teha_pkg::cmd_t      cmd
);
    import teha_pkg::*;

    logic [2:0]  base_reg;
    logic [2:0]  klen_reg;
    logic [15:0] series_reg;
    logic [15:0] step_reg;
    logic [7:0]  hist_reg;
    logic [1:0]  prev_reg;
    logic        full_reg;
    cmd_t        cmd_reg;

    logic [2:0]  b_eff;
    logic [3:0]  k_eff;
    logic [8:0]  q;
    logic        bad;
    logic        warm;
    logic [9:0]  pred;
    logic [9:0]  srci;
    logic [11:0] joint;
    logic [9:0]  hnext;
    logic [15:0] step_inc;
    cmd_t        cmd_next;
    logic        take;

    // effective base and history length
    always_comb begin
        b_eff = base_reg;
        if (base_reg < 3'd2) b_eff = 3'd2;
        if (32'(base_reg) > BASE_MAX_DEF) b_eff = 3'(BASE_MAX_DEF);
        k_eff = {1'b0, klen_reg};
        if (klen_reg == 3'd0) k_eff = 4'd1;
        if (32'(klen_reg) > HISTORY_MAX_DEF) k_eff = 4'(HISTORY_MAX_DEF);
    end

    // b^k: base is 2..4, k is 1..4
    always_comb begin
        case (b_eff)
            3'd2:    q = 9'd1 << k_eff;
            3'd4:    q = 9'd1 << {k_eff, 1'b0};
            default: begin
                case (k_eff)
                    4'd1:    q = 9'd3;
                    4'd2:    q = 9'd9;
                    4'd3:    q = 9'd27;
                    default: q = 9'd81;
                endcase
            end
        endcase
    end

    // index arithmetic, all small multiplies by b
    always_comb begin
        bad   = ({1'b0, source_symbol} >= b_eff) || ({1'b0, dest_symbol} >= b_eff);
        warm  = {12'd0, k_eff} > step_reg;
        pred  = 10'(hist_reg * b_eff) + 10'(dest_symbol);
        srci  = 10'(hist_reg * b_eff) + 10'(prev_reg);
        joint = 12'(pred * b_eff) + 12'(prev_reg);
        hnext = pred;
        if (hnext >= {1'b0, q}) hnext = hnext - {1'b0, q};
        if (hnext >= {1'b0, q}) hnext = hnext - {1'b0, q};
        if (hnext >= {1'b0, q}) hnext = hnext - {1'b0, q};
        step_inc = step_reg + 16'd1;
    end

    assign in_ready  = !full_reg || cmd_ready;
    assign take      = in_valid && in_ready;
    assign cmd_valid = full_reg;
    assign cmd       = cmd_reg;

    always_comb begin
        cmd_next           = '0;
        cmd_next.op        = operation;
        cmd_next.sel       = table_select;
        cmd_next.read_idx  = read_index;
        if (operation == OP_OBSERVE) begin
            cmd_next.bad = bad;
            if (!bad && !warm) begin
                cmd_next.counted   = 1'b1;
                cmd_next.joint_idx = joint;
                cmd_next.hist_idx  = hist_reg;
                cmd_next.src_idx   = srci;
                cmd_next.pred_idx  = pred;
                cmd_next.joint_ok  = 1'b1;
                cmd_next.src_ok    = 1'b1;
                cmd_next.pred_ok   = 1'b1;
            end
        end
    end

    // config and series state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= 3'd2;
            klen_reg   <= 3'd1;
            series_reg <= 16'd2;
            step_reg   <= '0;
            hist_reg   <= '0;
            prev_reg   <= '0;
            full_reg   <= 1'b0;
        end else begin
            if (take) begin
                full_reg <= 1'b1;
                cmd_reg  <= cmd_next;
            end else if (cmd_ready) begin
                full_reg <= 1'b0;
            end
            if (cfg_we && cfg_index != 2'd3) begin
                case (cfg_index)
                    CFG_BASE:    base_reg   <= cfg_data[2:0];
                    CFG_HISTORY: klen_reg   <= cfg_data[2:0];
                    default:     series_reg <= cfg_data;
                endcase
                step_reg <= '0;
                hist_reg <= '0;
                prev_reg <= '0;
            end else if (take && operation == OP_OBSERVE && !bad) begin
                prev_reg <= source_symbol;
                if (step_inc >= series_reg) begin
                    step_reg <= '0;
                    hist_reg <= '0;
                end else begin
                    step_reg <= step_inc;
                    hist_reg <= hnext[7:0];
                end
            end
        end
    end
endmodule

FILE: rtl/teha_back.sv
// ============================================================================
// teha_back
// Histogram read-modify-write, reads, and the clearing sweep.
// ============================================================================
module teha_back #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  teha_pkg::cmd_t cmd,
    output logic           m_valid,
    input  logic           m_ready,
    output logic           m_counted,
    output logic           m_bad_symbol,
    output logic [11:0]    m_joint_index,
    output logic [7:0]     m_history_index,
    output logic [9:0]     m_source_index,
    output logic [9:0]     m_predicate_index,
    output logic [31:0]    m_read_count,
    output logic [31:0]    m_total_observations
);
    import teha_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RMW   = 2'd1;
    localparam logic [1:0] ST_CLEAR = 2'd2;
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    logic [1:0]             state_reg, state_next;
    logic [11:0]            sweep_reg;
    logic                   clr_reg;
    logic [COUNT_WIDTH-1:0] total_reg;
    cmd_t                   cur_reg;
    logic                   out_reg;

    logic                   we;
    logic [11:0]            a_j;
    logic [7:0]             a_h;
    logic [9:0]             a_s, a_p;
    logic [COUNT_WIDTH-1:0] r_j, r_h, r_s, r_p;
    logic [COUNT_WIDTH-1:0] w_j, w_h, w_s, w_p;
    logic                   we_j, we_s, we_p;
    logic [COUNT_WIDTH-1:0] rsel;

    // addresses: sweep while clearing, else the command in flight
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            a_j = sweep_reg; a_h = sweep_reg[7:0];
            a_s = sweep_reg[9:0]; a_p = sweep_reg[9:0];
        end else if (state_reg == ST_RMW) begin
            a_j = cur_reg.op == OP_READ ? cur_reg.read_idx : cur_reg.joint_idx;
            a_h = cur_reg.op == OP_READ ? cur_reg.read_idx[7:0] : cur_reg.hist_idx;
            a_s = cur_reg.op == OP_READ ? cur_reg.read_idx[9:0] : cur_reg.src_idx;
            a_p = cur_reg.op == OP_READ ? cur_reg.read_idx[9:0] : cur_reg.pred_idx;
        end else begin
            a_j = cmd.op == OP_READ ? cmd.read_idx : cmd.joint_idx;
            a_h = cmd.op == OP_READ ? cmd.read_idx[7:0] : cmd.hist_idx;
            a_s = cmd.op == OP_READ ? cmd.read_idx[9:0] : cmd.src_idx;
            a_p = cmd.op == OP_READ ? cmd.read_idx[9:0] : cmd.pred_idx;
        end
    end

    // saturating increments, and zero writes while clearing
    always_comb begin
        we   = state_reg == ST_RMW && cur_reg.counted;
        w_j  = r_j == CMAX ? r_j : r_j + 1'b1;
        w_h  = r_h == CMAX ? r_h : r_h + 1'b1;
        w_s  = r_s == CMAX ? r_s : r_s + 1'b1;
        w_p  = r_p == CMAX ? r_p : r_p + 1'b1;
        we_j = we && cur_reg.joint_ok;
        we_s = we && cur_reg.src_ok;
        we_p = we && cur_reg.pred_ok;
        if (state_reg == ST_CLEAR) begin
            w_j = '0; w_h = '0; w_s = '0; w_p = '0;
            we_j = 1'b1; we_s = sweep_reg < 12'(PAIR_DEPTH); we_p = we_s;
        end
    end

    teha_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(JOINT_DEPTH)) u_joint (
        .aclk(aclk), .we(we_j), .waddr(a_j), .wdata(w_j), .raddr(a_j), .rdata(r_j));
    teha_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(HIST_DEPTH)) u_hist (
        .aclk(aclk), .we(state_reg == ST_CLEAR ? sweep_reg < 12'(HIST_DEPTH) : we),
        .waddr(a_h), .wdata(w_h), .raddr(a_h), .rdata(r_h));
    teha_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(PAIR_DEPTH)) u_src (
        .aclk(aclk), .we(we_s), .waddr(a_s), .wdata(w_s), .raddr(a_s), .rdata(r_s));
    teha_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(PAIR_DEPTH)) u_pred (
        .aclk(aclk), .we(we_p), .waddr(a_p), .wdata(w_p), .raddr(a_p), .rdata(r_p));

    // read selection with range check
    always_comb begin
        rsel = '0;
        case (cur_reg.sel)
            SEL_JOINT: rsel = r_j;
            SEL_HIST:  rsel = cur_reg.read_idx < 12'(HIST_DEPTH) ? r_h : '0;
            SEL_SRC:   rsel = cur_reg.read_idx < 12'(PAIR_DEPTH) ? r_s : '0;
            default:   rsel = cur_reg.read_idx < 12'(PAIR_DEPTH) ? r_p : '0;
        endcase
    end

    assign cmd_ready = state_reg == ST_IDLE && (!out_reg || m_ready);
    assign m_valid   = out_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (cmd_valid && cmd_ready) state_next = ST_RMW;
            ST_RMW:   state_next = cur_reg.op == OP_CLEAR ? ST_CLEAR : ST_IDLE;
            ST_CLEAR: if (sweep_reg == 12'(JOINT_DEPTH - 1)) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            sweep_reg <= '0;
            total_reg <= '0;
            out_reg   <= 1'b0;
            clr_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            // result valid: set when formed, dropped on transfer
            if (state_reg == ST_CLEAR && sweep_reg == 12'(JOINT_DEPTH - 1) && clr_reg) begin
                out_reg <= 1'b1;
            end else if (state_reg == ST_RMW && cur_reg.op != OP_CLEAR) begin
                out_reg <= 1'b1;
            end else if (m_ready) begin
                out_reg <= 1'b0;
            end
            if (state_reg == ST_IDLE && cmd_valid && cmd_ready) cur_reg <= cmd;
            if (state_reg == ST_CLEAR) begin
                sweep_reg <= sweep_reg + 12'd1;
                if (sweep_reg == 12'(JOINT_DEPTH - 1) && clr_reg) begin
                    clr_reg <= 1'b0;
                end
            end
            // result transfer formed at end of the access cycle
            if (state_reg == ST_RMW) begin
                m_counted         <= cur_reg.counted;
                m_bad_symbol      <= cur_reg.bad;
                m_joint_index     <= cur_reg.joint_idx;
                m_history_index   <= cur_reg.hist_idx;
                m_source_index    <= cur_reg.src_idx;
                m_predicate_index <= cur_reg.pred_idx;
                m_read_count      <= cur_reg.op == OP_READ ? 32'(rsel) : 32'd0;
                if (cur_reg.op == OP_CLEAR) begin
                    total_reg            <= '0;
                    m_total_observations <= '0;
                    sweep_reg            <= '0;
                    clr_reg              <= 1'b1;
                end else begin
                    if (cur_reg.counted && total_reg != CMAX) begin
                        total_reg            <= total_reg + 1'b1;
                        m_total_observations <= 32'(total_reg + 1'b1);
                    end else begin
                        m_total_observations <= 32'(total_reg);
                    end
                end
            end
        end
    end
endmodule

FILE: verif/transfer_entropy_histogram_accumulator_test.sv
// ----------------------------------------------------------------------------
// transfer_entropy_histogram_accumulator_test
// Self-checking bench for the transfer entropy histogram accumulator. A short
// table of directed steps runs first, followed by phases of random steps under
// a range of register settings, extremes and out-of-range values included.
// Every result is compared against an in-bench prediction of the histograms,
// with random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module transfer_entropy_histogram_accumulator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import teha_pkg::*;

    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam longint      COUNT_LIMIT = 64'hFFFF_FFFF;
    localparam longint      CYCLE_LIMIT = 3_000_000;
    localparam int          PHASE_ITEMS = 150;

    typedef struct {
        logic        counted;
        logic        bad;
        logic [11:0] joint;
        logic [7:0]  hist;
        logic [9:0]  src;
        logic [9:0]  pred;
        logic [31:0] rcount;
        logic [31:0] total;
    } step_result_t;

    typedef struct {
        logic [1:0]  op;
        logic [1:0]  src;
        logic [1:0]  dst;
        logic [1:0]  sel;
        logic [11:0] idx;
        bit          typed;
        logic        typed_bad;
        logic [31:0] typed_total;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation = '0;
    logic [1:0]  s_source_symbol = '0;
    logic [1:0]  s_dest_symbol = '0;
    logic [1:0]  s_table_select = '0;
    logic [11:0] s_read_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_counted;
    logic        m_bad_symbol;
    logic [11:0] m_joint_index;
    logic [7:0]  m_history_index;
    logic [9:0]  m_source_index;
    logic [9:0]  m_predicate_index;
    logic [31:0] m_read_count;
    logic [31:0] m_total_observations;

    // predicted block state
    logic [2:0]  base_reg;
    logic [2:0]  hist_len_reg;
    logic [15:0] series_len_reg;
    logic [15:0] step_count;
    logic [7:0]  history_word;
    logic [1:0]  prev_source;
    longint      joint_counts[JOINT_DEPTH];
    longint      hist_counts[HIST_DEPTH];
    longint      src_counts[PAIR_DEPTH];
    longint      pred_counts[PAIR_DEPTH];
    longint      observed_total;

    step_result_t awaited_results[$];
    stim_row_t    directed_rows[$];
    logic [11:0]  recent_index[4];
    int           mismatches = 0;
    bit           quiet = 1'b0;
    longint       cycles = 0;
    int           stall_left = 0;

    transfer_entropy_histogram_accumulator DUT (.*);

    always #6 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side stalls
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    task automatic clear_counts();
        foreach (joint_counts[i]) joint_counts[i] = 0;
        foreach (hist_counts[i]) hist_counts[i] = 0;
        foreach (src_counts[i]) src_counts[i] = 0;
        foreach (pred_counts[i]) pred_counts[i] = 0;
        observed_total = 0;
    endtask

    task automatic restart_series();
        step_count = '0;
        history_word = '0;
        prev_source = '0;
    endtask

    task automatic bump(ref longint cnt);
        if (cnt < COUNT_LIMIT) cnt++;
    endtask

    // histogram step prediction
    task automatic predict_step(input logic [1:0] op, input logic [1:0] src,
                                input logic [1:0] dst, input logic [1:0] sel,
                                input logic [11:0] idx, output step_result_t res);
        int b;
        int k;
        int q;
        int h;
        int pr;
        int si;
        int jn;
        res = '{default: '0};
        if (op == OP_OBSERVE) begin
            b = (base_reg < 2) ? 2 : (base_reg > BASE_MAX_DEF) ? BASE_MAX_DEF : base_reg;
            k = (hist_len_reg < 1) ? 1 :
                (hist_len_reg > HISTORY_MAX_DEF) ? HISTORY_MAX_DEF : hist_len_reg;
            if (src >= b || dst >= b) begin
                res.bad = 1'b1;
            end else begin
                q = 1;
                for (int i = 0; i < k; i++) q = q * b;
                h = history_word;
                if (step_count < k) begin
                    history_word = 8'((h * b + dst) % q);
                end else begin
                    pr = h * b + dst;
                    si = h * b + prev_source;
                    jn = pr * b + prev_source;
                    if (jn < JOINT_DEPTH) bump(joint_counts[jn]);
                    if (h < HIST_DEPTH) bump(hist_counts[h]);
                    if (si < PAIR_DEPTH) bump(src_counts[si]);
                    if (pr < PAIR_DEPTH) bump(pred_counts[pr]);
                    if (observed_total < COUNT_LIMIT) observed_total++;
                    res.counted = 1'b1;
                    res.joint = 12'(jn);
                    res.hist = 8'(h);
                    res.src = 10'(si);
                    res.pred = 10'(pr);
                    recent_index[SEL_JOINT] = 12'(jn);
                    recent_index[SEL_HIST] = 12'(h);
                    recent_index[SEL_SRC] = 12'(si);
                    recent_index[SEL_PRED] = 12'(pr);
                    history_word = 8'(pr % q);
                end
                prev_source = src;
                step_count = step_count + 16'd1;
                if (step_count >= series_len_reg) begin
                    step_count = '0;
                    history_word = '0;
                end
            end
        end else if (op == OP_READ) begin
            case (sel)
                SEL_JOINT: res.rcount = 32'(joint_counts[idx]);
                SEL_HIST:  res.rcount = (idx < HIST_DEPTH) ? 32'(hist_counts[idx]) : 32'd0;
                SEL_SRC:   res.rcount = (idx < PAIR_DEPTH) ? 32'(src_counts[idx]) : 32'd0;
                default:   res.rcount = (idx < PAIR_DEPTH) ? 32'(pred_counts[idx]) : 32'd0;
            endcase
        end else if (op == OP_CLEAR) begin
            clear_counts();
        end
        res.total = 32'(observed_total);
    endtask

    // one input transfer, with its gap before it
    task automatic send_step(input stim_row_t row);
        int gap;
        step_result_t res;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= row.op;
        s_source_symbol <= row.src;
        s_dest_symbol <= row.dst;
        s_table_select <= row.sel;
        s_read_index <= row.idx;
        do @(posedge aclk); while (!s_ready);
        predict_step(row.op, row.src, row.dst, row.sel, row.idx, res);
        if (row.typed) begin
            res = '{default: '0};
            res.bad = row.typed_bad;
            res.total = row.typed_total;
        end
        awaited_results.push_back(res);
    endtask

    // register writes once the block has drained
    task automatic write_settings(input logic [2:0] b, input logic [2:0] k,
                                  input logic [15:0] m);
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_BASE;
        cfg_data <= {13'd0, b};
        @(posedge aclk);
        cfg_index <= CFG_HISTORY;
        cfg_data <= {13'd0, k};
        @(posedge aclk);
        cfg_index <= CFG_SERIES;
        cfg_data <= m;
        @(posedge aclk);
        cfg_we <= 1'b0;
        base_reg = b;
        hist_len_reg = k;
        series_len_reg = m;
        restart_series();
    endtask

    task automatic add_row(input logic [1:0] op, input logic [1:0] src,
                           input logic [1:0] dst, input logic [1:0] sel,
                           input logic [11:0] idx, input bit typed, input logic bad);
        stim_row_t row;
        row = '{op, src, dst, sel, idx, typed, bad, 32'd0};
        directed_rows.push_back(row);
    endtask

    function automatic stim_row_t random_row();
        stim_row_t row;
        int r;
        row = '{default: '0};
        r = $urandom_range(0, 999);
        row.src = 2'($urandom_range(0, 3));
        row.dst = 2'($urandom_range(0, 3));
        row.sel = 2'($urandom_range(0, 3));
        row.idx = 12'($urandom_range(0, 4095));
        if (r < 800) begin
            row.op = OP_OBSERVE;
            // mostly legal symbols for the active base
            if ($urandom_range(0, 9) != 0 && base_reg >= 2 && base_reg <= 4) begin
                row.src = 2'($urandom_range(0, base_reg - 1));
                row.dst = 2'($urandom_range(0, base_reg - 1));
            end
        end else if (r < 970) begin
            row.op = OP_READ;
            if ($urandom_range(0, 1) == 0) row.idx = recent_index[row.sel];
        end else if (r < 980) begin
            row.op = OP_CLEAR;
        end else begin
            row.op = OP_UNUSED;
        end
        return row;
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t %s expected %0d actual %0d", $realtime, name, want, got);
            mismatches++;
        end
    endfunction

    // result checking
    always @(posedge aclk) begin
        step_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t unexpected result expected none actual total %0d",
                         $realtime, m_total_observations);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                check_field("counted", want.counted, m_counted);
                check_field("bad_symbol", want.bad, m_bad_symbol);
                check_field("joint_index", want.joint, m_joint_index);
                check_field("history_index", want.hist, m_history_index);
                check_field("source_index", want.src, m_source_index);
                check_field("predicate_index", want.pred, m_predicate_index);
                check_field("read_count", want.rcount, m_read_count);
                check_field("total_observations", want.total, m_total_observations);
            end
        end
    end

    // stimulus
    initial begin
        logic [2:0]  phase_base[8];
        logic [2:0]  phase_hist[8];
        logic [15:0] phase_len[8];
        phase_base = '{3'd2, 3'd4, 3'd4, 3'd0, 3'd7, 3'd3, 3'd2, 3'd3};
        phase_hist = '{3'd1, 3'd4, 3'd4, 3'd0, 3'd7, 3'd2, 3'd4, 3'd3};
        phase_len  = '{16'd2, 16'd65535, 16'd9, 16'd1, 16'd20, 16'd7, 16'd4, 16'd0};
        base_reg = 3'd2;
        hist_len_reg = 3'd1;
        series_len_reg = 16'd2;
        restart_series();
        clear_counts();
        foreach (recent_index[i]) recent_index[i] = '0;

        // empty tables, extremes of the read index, bad symbols, unused opcode
        add_row(OP_READ, 2'd0, 2'd0, SEL_JOINT, 12'd0, 1, 1'b0);
        add_row(OP_READ, 2'd3, 2'd3, SEL_JOINT, 12'd4095, 1, 1'b0);
        add_row(OP_READ, 2'd0, 2'd0, SEL_HIST, 12'd255, 1, 1'b0);
        add_row(OP_READ, 2'd0, 2'd0, SEL_HIST, 12'd4095, 1, 1'b0);
        add_row(OP_READ, 2'd0, 2'd0, SEL_SRC, 12'd1023, 1, 1'b0);
        add_row(OP_READ, 2'd0, 2'd0, SEL_PRED, 12'd4095, 1, 1'b0);
        add_row(OP_UNUSED, 2'd3, 2'd3, SEL_PRED, 12'd4095, 1, 1'b0);
        add_row(OP_OBSERVE, 2'd3, 2'd0, SEL_JOINT, 12'd0, 1, 1'b1);
        add_row(OP_OBSERVE, 2'd0, 2'd2, SEL_JOINT, 12'd0, 1, 1'b1);
        // warm-up, counted step, series wrap
        add_row(OP_OBSERVE, 2'd0, 2'd1, SEL_JOINT, 12'd0, 0, 1'b0);
        add_row(OP_OBSERVE, 2'd1, 2'd1, SEL_JOINT, 12'd0, 0, 1'b0);
        add_row(OP_OBSERVE, 2'd1, 2'd0, SEL_JOINT, 12'd0, 0, 1'b0);
        add_row(OP_OBSERVE, 2'd0, 2'd1, SEL_JOINT, 12'd0, 0, 1'b0);
        add_row(OP_OBSERVE, 2'd1, 2'd1, SEL_JOINT, 12'd0, 0, 1'b0);
        add_row(OP_OBSERVE, 2'd1, 2'd1, SEL_JOINT, 12'd0, 0, 1'b0);
        add_row(OP_READ, 2'd0, 2'd0, SEL_JOINT, 12'd7, 0, 1'b0);
        add_row(OP_READ, 2'd0, 2'd0, SEL_HIST, 12'd1, 0, 1'b0);
        add_row(OP_READ, 2'd0, 2'd0, SEL_SRC, 12'd3, 0, 1'b0);
        add_row(OP_READ, 2'd0, 2'd0, SEL_PRED, 12'd3, 0, 1'b0);
        // clear keeps series tracking
        add_row(OP_CLEAR, 2'd0, 2'd0, SEL_JOINT, 12'd0, 0, 1'b0);
        add_row(OP_READ, 2'd0, 2'd0, SEL_JOINT, 12'd7, 0, 1'b0);
        add_row(OP_OBSERVE, 2'd1, 2'd0, SEL_JOINT, 12'd0, 0, 1'b0);
        add_row(OP_OBSERVE, 2'd0, 2'd0, SEL_JOINT, 12'd0, 0, 1'b0);
        add_row(OP_UNUSED, 2'd0, 2'd0, SEL_JOINT, 12'd0, 0, 1'b0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed_rows[i]) send_step(directed_rows[i]);

        // random phases under varied settings
        for (int p = 0; p < 8; p++) begin
            write_settings(phase_base[p], phase_hist[p], phase_len[p]);
            quiet = (p % 3 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) send_step(random_row());
        end
        s_valid <= 1'b0;

        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/teha_pkg.sv
rtl/teha_ram.sv
rtl/teha_front.sv
rtl/teha_back.sv
rtl/transfer_entropy_histogram_accumulator.sv
verif/transfer_entropy_histogram_accumulator_test.sv
